// ----- src/iroot_pkg.sv -----
// Shared types, constants and the prime table for the integer root simplifier.
// Used by every module in src; depends on nothing.
package iroot_pkg;

    localparam int PRIME_BITS     = 10;
    localparam int TABLE_SIZE     = 168;
    localparam int TABLE_IDX_BITS = 8;
    localparam int RUN_BITS       = 5;

    localparam int NUM_PRIMES_DEF = 168;
    localparam int VALUE_BITS_DEF = 20;

    localparam logic [PRIME_BITS-1:0] PRIME_ROM [TABLE_SIZE] = '{
        10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
        10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
        10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
        10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
        10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
        10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
        10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
        10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
        10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
        10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
        10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
        10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
        10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
        10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
        10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
        10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
        10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
        10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
        10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
        10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
        10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_TAKE,
        S_TAKE_LAST,
        S_CLOSE,
        S_FINISH
    } iroot_state_t;

    // Commands from the sequencer to the run accumulator
    typedef struct packed {
        logic init;
        logic take;
        logic close;
    } iroot_acc_cmd_t;

    // Status back from the run accumulator
    typedef struct packed {
        logic take_done;
        logic run_empty;
    } iroot_acc_stat_t;

    function automatic logic [PRIME_BITS-1:0] prime_at(input logic [TABLE_IDX_BITS-1:0] idx);
        logic [PRIME_BITS-1:0] p;
        p = '0;
        if (idx < TABLE_IDX_BITS'(TABLE_SIZE))
        begin
            p = PRIME_ROM[idx];
        end
        return p;
    endfunction

endpackage

// ----- src/iroot_divider.sv -----
// Shared restoring divider: one quotient bit per cycle, prime-width divisor.
// Depends on iroot_pkg.
module iroot_divider
    import iroot_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [PRIME_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic                  rem_zero
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  active_reg, active_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [PRIME_BITS-1:0] rem_reg, rem_next;
    logic [PRIME_BITS-1:0] div_reg, div_next;
    logic [PRIME_BITS:0]   rem_shift;
    logic                  fits;

    assign rem_shift = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_BITS'(VALUE_BITS);
            q_next      = dividend;
            rem_next    = '0;
            div_next    = divisor;
        end
        else if (active_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_BITS'(1);
                q_next   = {q_reg[VALUE_BITS-2:0], fits};
                rem_next = fits ? PRIME_BITS'(rem_shift - {1'b0, div_reg})
                                : PRIME_BITS'(rem_shift);
            end
            else
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = active_reg && (cnt_reg == '0);
    assign quotient = q_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ----- src/iroot_run_accum.sv -----
// Run tracking and the two products; one shared multiplier serves both.
// Depends on iroot_pkg.
module iroot_run_accum
    import iroot_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  iroot_acc_cmd_t        cmd,
    input  logic [VALUE_BITS-1:0] factor,
    input  logic [RUN_BITS-1:0]   root,
    output iroot_acc_stat_t       stat,
    output logic [VALUE_BITS-1:0] inner_prod,
    output logic [VALUE_BITS-1:0] outside
);

    logic [VALUE_BITS-1:0]   inside_reg, inside_next;
    logic [VALUE_BITS-1:0]   outside_reg, outside_next;
    logic [VALUE_BITS-1:0]   run_factor_reg, run_factor_next;
    logic [RUN_BITS-1:0]     run_count_reg, run_count_next;
    logic [RUN_BITS:0]       count_inc;
    logic                    new_factor;
    logic                    flush_one;
    logic                    use_outside;
    logic [VALUE_BITS-1:0]   mul_a, mul_b;
    logic [2*VALUE_BITS-1:0] mul_full;
    logic [VALUE_BITS-1:0]   mul_res;

    assign new_factor = (factor != run_factor_reg);
    // a new factor first drains the open run, one copy per cycle
    assign flush_one  = new_factor && (run_count_reg != '0);
    assign count_inc  = {1'b0, run_count_reg} + (RUN_BITS+1)'(1);
    assign use_outside = cmd.take && !flush_one;

    assign mul_a    = use_outside ? outside_reg : inside_reg;
    assign mul_b    = use_outside ? factor : run_factor_reg;
    assign mul_full = mul_a * mul_b;
    assign mul_res  = mul_full[VALUE_BITS-1:0];

    always_comb
    begin
        inside_next     = inside_reg;
        outside_next    = outside_reg;
        run_factor_next = run_factor_reg;
        run_count_next  = run_count_reg;
        priority if (cmd.init)
        begin
            inside_next     = VALUE_BITS'(1);
            outside_next    = VALUE_BITS'(1);
            run_factor_next = '0;
            run_count_next  = '0;
        end
        else if (cmd.take)
        begin
            if (flush_one)
            begin
                inside_next    = mul_res;
                run_count_next = run_count_reg - RUN_BITS'(1);
            end
            else
            begin
                run_factor_next = factor;
                if (count_inc >= {1'b0, root})
                begin
                    outside_next   = mul_res;
                    run_count_next = '0;
                end
                else
                begin
                    run_count_next = RUN_BITS'(count_inc);
                end
            end
        end
        else if (cmd.close)
        begin
            if (run_count_reg != '0)
            begin
                inside_next    = mul_res;
                run_count_next = run_count_reg - RUN_BITS'(1);
            end
        end
        else
        begin
            // hold everything
            run_count_next = run_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg     <= VALUE_BITS'(1);
            outside_reg    <= VALUE_BITS'(1);
            run_factor_reg <= '0;
            run_count_reg  <= '0;
        end
        else
        begin
            inside_reg     <= inside_next;
            outside_reg    <= outside_next;
            run_factor_reg <= run_factor_next;
            run_count_reg  <= run_count_next;
        end
    end

    assign stat.take_done = !flush_one;
    assign stat.run_empty = (run_count_reg == '0);
    assign inner_prod     = inside_reg;
    assign outside        = outside_reg;

endmodule

// ----- src/integer_root_simplifier_top.sv -----
// Top level of the integer root simplifier: sequencer, work registers, output stage.
// Depends on iroot_pkg, iroot_divider and iroot_run_accum.
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+----------------------------------
//  in      | in_valid / in_ready            | request   | value, root_index
//  out     | out_valid / out_ready          | result    | radicand, coefficient
//
// Flow: each trial division is a check followed by a bit-serial divide, and a prime is
//   tried again after every factor it yields; every factor found is taken into the run,
//   after the open run of an older factor is flushed, and the final close flushes the
//   open run under the root.
// Reset: rst_n clears the sequencer, the divider control, the run accumulator and the output valid.
// Stalls: a new request is taken as soon as the sequencer is idle, even while the last
//   result still waits in the output register; the sequencer only holds at its end
//   if that register is still full.
module integer_root_simplifier_top
    import iroot_pkg::*;
#(
    parameter int NUM_PRIMES = NUM_PRIMES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [RUN_BITS-1:0]   root_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] radicand,
    output logic [VALUE_BITS-1:0] coefficient
);

    // only the built-in table primes can be walked
    localparam int LIMIT    = (NUM_PRIMES < TABLE_SIZE) ? NUM_PRIMES : TABLE_SIZE;
    localparam int POS_BITS = $clog2(LIMIT + 1);
    localparam int CMP_BITS = (VALUE_BITS > PRIME_BITS) ? VALUE_BITS : PRIME_BITS;

    iroot_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] work_reg, work_next;
    logic [VALUE_BITS-1:0] factor_reg, factor_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [RUN_BITS-1:0]   root_reg, root_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] radicand_reg, radicand_next;
    logic [VALUE_BITS-1:0] coefficient_reg, coefficient_next;

    logic                  in_fire;
    logic [PRIME_BITS-1:0] prime;
    logic                  stop_trial;
    logic                  has_leftover;

    // sequencer outputs
    logic                  div_start;
    logic                  take_quotient;
    logic                  next_prime;
    logic                  take_leftover;
    logic                  out_load;
    iroot_acc_cmd_t        acc_cmd;

    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic                  div_rem_zero;
    iroot_acc_stat_t       acc_stat;
    logic [VALUE_BITS-1:0] acc_inside;
    logic [VALUE_BITS-1:0] acc_outside;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // current trial prime from the constant table
    assign prime = prime_at(TABLE_IDX_BITS'(pos_reg));

    // stop trial division when the table runs out or the value is no longer above the prime
    assign stop_trial = (pos_reg == POS_BITS'(LIMIT))
                     || (CMP_BITS'(work_reg) <= CMP_BITS'(prime));
    assign has_leftover = (work_reg > VALUE_BITS'(1));

    iroot_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (work_reg),
        .divisor  (prime),
        .done     (div_done),
        .quotient (div_quotient),
        .rem_zero (div_rem_zero)
    );

    iroot_run_accum #(
        .VALUE_BITS (VALUE_BITS)
    ) u_run_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (acc_cmd),
        .factor     (factor_reg),
        .root       (root_reg),
        .stat       (acc_stat),
        .inner_prod (acc_inside),
        .outside    (acc_outside)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stop_trial)
                begin
                    state_next = S_DIV;
                end
                else if (has_leftover)
                begin
                    state_next = S_TAKE_LAST;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = div_rem_zero ? S_TAKE : S_CHECK;
                end
            end
            S_TAKE:
            begin
                if (acc_stat.take_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_TAKE_LAST:
            begin
                if (acc_stat.take_done)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                if (acc_stat.run_empty)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start     = 1'b0;
        take_quotient = 1'b0;
        next_prime    = 1'b0;
        take_leftover = 1'b0;
        out_load      = 1'b0;
        acc_cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                acc_cmd.init = in_fire;
            end
            S_CHECK:
            begin
                div_start     = !stop_trial;
                take_leftover = stop_trial && has_leftover;
            end
            S_DIV:
            begin
                take_quotient = div_done && div_rem_zero;
                next_prime    = div_done && !div_rem_zero;
            end
            S_TAKE, S_TAKE_LAST:
            begin
                acc_cmd.take = 1'b1;
            end
            S_CLOSE:
            begin
                acc_cmd.close = 1'b1;
            end
            S_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // work registers
    always_comb
    begin
        work_next   = work_reg;
        factor_next = factor_reg;
        pos_next    = pos_reg;
        root_next   = root_reg;
        if (in_fire)
        begin
            work_next = value;
            pos_next  = '0;
            // a root index of zero acts as one
            root_next = (root_index == '0) ? RUN_BITS'(1) : root_index;
        end
        if (take_quotient)
        begin
            work_next   = div_quotient;
            factor_next = VALUE_BITS'(prime);
        end
        if (next_prime)
        begin
            pos_next = pos_reg + POS_BITS'(1);
        end
        if (take_leftover)
        begin
            factor_next = work_reg;
        end
    end

    // output register: load on finish, drop valid once taken
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        radicand_next    = radicand_reg;
        coefficient_next = coefficient_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            radicand_next    = acc_inside;
            coefficient_next = acc_outside;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg        <= work_next;
        factor_reg      <= factor_next;
        root_reg        <= root_next;
        radicand_reg    <= radicand_next;
        coefficient_reg <= coefficient_next;
    end

    assign out_valid   = out_valid_reg;
    assign radicand    = radicand_reg;
    assign coefficient = coefficient_reg;

endmodule

// ----- verif/root_simplify_checker.sv -----
`timescale 1ns / 100ps
// Checker for the integer root simplifier: watches both channels, predicts each result
// by trial division and compares it field by field. Depends on iroot_pkg.
module root_simplify_checker
    import iroot_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [VALUE_BITS_DEF-1:0] value,
    input  logic [RUN_BITS-1:0]       root_index,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [VALUE_BITS_DEF-1:0] radicand,
    input  logic [VALUE_BITS_DEF-1:0] coefficient,
    output int                        mismatch_count,
    output int                        outstanding
);

    localparam int VW = VALUE_BITS_DEF;
    localparam longint unsigned VMASK = (64'd1 << VW) - 1;
    // Largest trial divisor; composites below it never divide once their primes are gone.
    localparam longint unsigned LAST_TRIAL = 997;

    typedef struct {
        logic [VW-1:0] radicand;
        logic [VW-1:0] coefficient;
    } root_result_t;

    root_result_t expected_roots [$];
    root_result_t oldest;

    // Predictor state, reloaded for every request
    longint unsigned open_factor;
    int              open_count;
    longint unsigned inner_prod;
    longint unsigned outer_prod;

    // Flush the open run under the root.
    function automatic void flush_run();
        while (open_count > 0)
        begin
            inner_prod = (inner_prod * open_factor) & VMASK;
            open_count--;
        end
        open_factor = 0;
    endfunction

    // Add one factor to its run; a full group of r moves one copy outside.
    function automatic void absorb_factor(input longint unsigned f, input int r);
        if (f != open_factor)
        begin
            flush_run();
            open_factor = f;
        end
        open_count++;
        if (open_count >= r)
        begin
            outer_prod = (outer_prod * f) & VMASK;
            open_count = 0;
        end
    endfunction

    function automatic root_result_t simplify_root(input logic [VW-1:0] v,
                                                   input logic [RUN_BITS-1:0] r_in);
        longint unsigned rest;
        longint unsigned d;
        int              r;
        root_result_t    res;
        r           = (r_in == '0) ? 1 : int'(r_in);
        rest        = v;
        d           = 2;
        open_factor = 0;
        open_count  = 0;
        inner_prod  = 1;
        outer_prod  = 1;
        while (d <= LAST_TRIAL && rest > d)
        begin
            if (rest % d == 0)
            begin
                absorb_factor(d, r);
                rest = rest / d;
            end
            else
            begin
                d++;
            end
        end
        // Leftover may be composite, or equal to the last divisor tried
        if (rest > 1)
        begin
            absorb_factor(rest, r);
        end
        flush_run();
        res.radicand    = inner_prod[VW-1:0];
        res.coefficient = outer_prod[VW-1:0];
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [VW-1:0] got,
                                 input logic [VW-1:0] want);
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_roots.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    note_mismatch("result with no request pending", radicand, '0);
                end
                else
                begin
                    oldest = expected_roots.pop_front();
                    if (radicand !== oldest.radicand)
                    begin
                        note_mismatch("radicand", radicand, oldest.radicand);
                    end
                    if (coefficient !== oldest.coefficient)
                    begin
                        note_mismatch("coefficient", coefficient, oldest.coefficient);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_roots = {expected_roots, simplify_root(value, root_index)};
            end
            outstanding = expected_roots.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the integer root simplifier: clock, reset, request and result drivers,
// watchdog and verdict. Depends on iroot_pkg, root_simplify_checker and the block's RTL.
module tb
    import iroot_pkg::*;
;

    localparam int VW = VALUE_BITS_DEF;
    localparam longint unsigned VALUE_MAX = (64'd1 << VW) - 1;
    localparam int RANDOM_REQUESTS = 112;
    localparam int HOLD_CYCLES = 2500;
    // Watchdog limit; it covers the slowest request plus one long result hold.
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 100;
    localparam int NUM_DIRECTED = 22;

    localparam int unsigned SMALL_PRIMES [8] = '{2, 3, 5, 7, 11, 13, 17, 19};
    // Primes just past the table: their products leave a composite leftover
    localparam int unsigned BIG_PRIMES [6] = '{1009, 1013, 1019, 1021, 1031, 1033};

    // Directed requests: zero and one, the field extremes, root index zero, a leftover
    // that joins the last prime's run, composite leftovers, and partial last groups.
    localparam logic [VW-1:0] DIR_VALUES [NUM_DIRECTED] = '{
        20'd0,      20'd1,      20'hFFFFF,  20'd0,      20'hFFFFF,  20'd1024,
        20'd4,      20'd1018081, 20'd1022117, 20'd994009, 20'd997,  20'd524288,
        20'd8,      20'd531441, 20'd2,      20'd720720, 20'd1048573, 20'd524287,
        20'd362880, 20'd65536,  20'hAAAAA,  20'h55555
    };
    localparam logic [RUN_BITS-1:0] DIR_ROOTS [NUM_DIRECTED] = '{
        5'd2,  5'd3,  5'd31, 5'd0,  5'd1,  5'd0,
        5'd2,  5'd2,  5'd1,  5'd2,  5'd1,  5'd3,
        5'd4,  5'd5,  5'd31, 5'd2,  5'd2,  5'd2,
        5'd3,  5'd16, 5'd21, 5'd10
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [VW-1:0]       value = '0;
    logic [RUN_BITS-1:0] root_index = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VW-1:0]       radicand;
    logic [VW-1:0]       coefficient;

    int mismatch_count;
    int outstanding;
    bit idle_enable = 1'b1;   // both sides draw random gaps while set
    int hold_requests = 0;    // bumped by the stimulus to ask for one long result hold
    int holds_served = 0;
    int quiet_cycles = 0;

    integer_root_simplifier_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .root_index  (root_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .radicand    (radicand),
        .coefficient (coefficient)
    );

    root_simplify_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .root_index     (root_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .radicand       (radicand),
        .coefficient    (coefficient),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offer one request after a random gap and hold it until the block takes it.
    // With no gap, valid simply stays high into the next request.
    task automatic send_request(input logic [VW-1:0] v, input logic [RUN_BITS-1:0] r);
        int gap;
        gap = idle_enable ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        value      <= v;
        root_index <= r;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // Build a value that gets past the first primes: mostly runs of small primes and
    // perfect powers, some plain random, some leftovers beyond the prime table, some corner values.
    function automatic logic [VW-1:0] pick_value();
        longint unsigned acc;
        longint unsigned base;
        longint unsigned other;
        int              kind;
        acc  = 1;
        kind = $urandom_range(0, 9);
        if (kind <= 1)
        begin
            acc = $urandom() & VALUE_MAX;
        end
        else if (kind <= 5)
        begin
            repeat ($urandom_range(1, 4))
            begin
                base = SMALL_PRIMES[$urandom_range(0, 7)];
                repeat ($urandom_range(1, 12))
                begin
                    if (acc * base <= VALUE_MAX)
                    begin
                        acc = acc * base;
                    end
                end
            end
        end
        else if (kind <= 7)
        begin
            base = $urandom_range(2, 40);
            repeat ($urandom_range(2, 8))
            begin
                if (acc * base <= VALUE_MAX)
                begin
                    acc = acc * base;
                end
            end
            other = $urandom_range(1, 50);
            if (acc * other <= VALUE_MAX)
            begin
                acc = acc * other;
            end
        end
        else if (kind == 8)
        begin
            base  = BIG_PRIMES[$urandom_range(0, 5)];
            other = BIG_PRIMES[$urandom_range(0, 5)];
            acc   = (base * other <= VALUE_MAX) ? base * other
                                                : base * $urandom_range(1, 1000);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: acc = 0;
                1: acc = 1;
                2: acc = VALUE_MAX;
                3: acc = 997 * $urandom_range(1, 1000);
                default: acc = $urandom_range(2, 64);
            endcase
        end
        return acc[VW-1:0];
    endfunction

    // Small root indexes most of the time so that groups actually fill.
    function automatic logic [RUN_BITS-1:0] pick_root();
        int r;
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
        return r[RUN_BITS-1:0];
    endfunction

    // Result side: stall a random number of cycles before each result, or hold off
    // for a long stretch when the stimulus asks for it.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_requests != holds_served)
            begin
                stall = HOLD_CYCLES;
                holds_served++;
            end
            else
            begin
                stall = idle_enable ? $urandom_range(0, 6) : 0;
            end
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        // Hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed corner cases
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            send_request(DIR_VALUES[i], DIR_ROOTS[i]);
        end
        drain_results();

        // Back-pressure: hold results off while cheap requests keep coming, so the
        // output register fills, the sequencer blocks and in_ready drops
        hold_requests++;
        repeat (6)
        begin
            send_request(20'd1 << $urandom_range(1, 10), pick_root());
        end
        // Pause the request side until everything has come back
        drain_results();

        // Random requests; every 25 requests redraw whether both sides idle
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i % 25 == 0)
            begin
                idle_enable = ($urandom_range(0, 2) != 0);
            end
            send_request(pick_value(), pick_root());
        end
        drain_results();

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/iroot_pkg.sv
src/iroot_divider.sv
src/iroot_run_accum.sv
src/integer_root_simplifier_top.sv
verif/root_simplify_checker.sv
verif/tb.sv
